// ----- rtl/bsc_pkg.sv -----
// shared constants for the bitmap set/clear/find-next block
package bsc_pkg;

  localparam int MODE_W     = 4;
  localparam int IDX_W      = 11;
  localparam int FIDX_W     = 10;
  localparam int WORD_W     = 64;
  localparam int WORD_SH    = 6;

  localparam int BIT_CAPACITY_DEF = 1024;

  localparam logic [MODE_W-1:0] MODE_GET        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SET        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_FLIP       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TEST_SET   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_TEST_CLEAR = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NEXT_SET   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_NEXT_CLEAR = 4'd7;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL  = 4'd8;

endpackage

// ----- rtl/bsc_in_if.sv -----
// request channel: operation and bit index
interface bsc_in_if;
  import bsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  bit_index;

  modport source (output valid, output mode, output bit_index, input ready);
  modport sink   (input valid, input mode, input bit_index, output ready);
endinterface

// ----- rtl/bsc_out_if.sv -----
// result channel: old bit, find result and map status
interface bsc_out_if;
  import bsc_pkg::*;

  logic              valid;
  logic              ready;
  logic              old_bit;
  logic              found;
  logic [FIDX_W-1:0] found_index;
  logic              out_of_range;
  logic              map_empty;

  modport source (output valid, output old_bit, output found, output found_index,
                  output out_of_range, output map_empty, input ready);
  modport sink   (input valid, input old_bit, input found, input found_index,
                  input out_of_range, input map_empty, output ready);
endinterface

// ----- rtl/bitmap_set_clear_find_next_top.sv -----
// Bitmap of BIT_CAPACITY bits held in a 64-bit-wide single-port-read memory, one
// request at a time. Get, set, clear, flip and the test variants go from acceptance
// to a valid result through one memory read, one read-modify-write and a load of
// the result register, which waits while the last result is still held unread.
// Find-next operations read one word per cycle starting at the word holding
// bit_index and stop at the first match or the last word. Clear all writes zero to
// every word, one per cycle; the same clearing pass runs after reset, during which
// no request is taken. A new request may be accepted while the last result still
// waits in the output register.
module bitmap_set_clear_find_next_top #(
  parameter int BIT_CAPACITY = bsc_pkg::BIT_CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bsc_in_if.sink   in_ch,
  bsc_out_if.source out_ch
);
  import bsc_pkg::*;

  localparam int NUM_WORDS = (BIT_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(BIT_CAPACITY + 1);
  localparam int LAST_BITS = BIT_CAPACITY - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_AW-1:0] LAST_W = WORD_AW'(NUM_WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK =
    (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCAN, S_DONE
  } state_t;

  state_t              state_r;
  logic [WORD_AW-1:0]  clr_addr_r;
  logic                clr_reply_r;
  logic [MODE_W-1:0]   mode_r;
  logic [IDX_W-1:0]    idx_r;
  logic [WORD_AW-1:0]  cur_w_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [WORD_W-1:0]   rd_data_r;

  logic                res_old_r;
  logic                res_found_r;
  logic [FIDX_W-1:0]   res_fidx_r;
  logic                res_oor_r;

  logic                out_valid_r;
  logic                out_old_r;
  logic                out_found_r;
  logic [FIDX_W-1:0]   out_fidx_r;
  logic                out_oor_r;
  logic                out_empty_r;

  logic [WORD_W-1:0]   mem [NUM_WORDS];

  logic                in_acc;
  logic                in_oor;
  logic [31:0]         in_word32;
  logic [WORD_AW-1:0]  rd_addr;
  logic                wr_en;
  logic [WORD_AW-1:0]  wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [WORD_W-1:0]   bit_mask;
  logic [WORD_W-1:0]   new_word;
  logic                old_bit;
  logic                is_find;
  logic                is_modify;
  logic                want;
  logic [WORD_W-1:0]   cand;
  logic                hit;
  logic [WORD_SH-1:0]  hit_pos;
  logic [31:0]         hit_full;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                out_free;

  // lowest set bit of a word
  function automatic logic [WORD_SH:0] first_one(input logic [WORD_W-1:0] v);
    logic [WORD_SH:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, WORD_SH'(i)};
      end
    end
    return r;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_oor      = (32'(in_ch.bit_index) >= 32'(BIT_CAPACITY));
  assign in_word32   = 32'(in_ch.bit_index) >> WORD_SH;

  assign rd_addr  = (state_r == S_IDLE) ? in_word32[WORD_AW-1:0]
                                        : WORD_AW'(cur_w_r + 1'b1);

  assign bit_mask  = WORD_W'(1) << idx_r[WORD_SH-1:0];
  assign old_bit   = rd_data_r[idx_r[WORD_SH-1:0]];
  assign is_find   = (mode_r == MODE_NEXT_SET) || (mode_r == MODE_NEXT_CLEAR);
  assign is_modify = (mode_r == MODE_SET) || (mode_r == MODE_CLEAR) ||
                     (mode_r == MODE_FLIP) || (mode_r == MODE_TEST_SET) ||
                     (mode_r == MODE_TEST_CLEAR);
  assign want      = (mode_r == MODE_NEXT_SET);

  always_comb begin
    case (mode_r)
      MODE_SET, MODE_TEST_SET:     new_word = rd_data_r | bit_mask;
      MODE_CLEAR, MODE_TEST_CLEAR: new_word = rd_data_r & ~bit_mask;
      MODE_FLIP:                   new_word = rd_data_r ^ bit_mask;
      default:                     new_word = rd_data_r;
    endcase
  end

  // population count tracks emptiness without scanning
  always_comb begin
    cnt_nxt = cnt_r;
    case (mode_r)
      MODE_SET, MODE_TEST_SET: begin
        if (!old_bit) cnt_nxt = cnt_r + 1'b1;
      end
      MODE_CLEAR, MODE_TEST_CLEAR: begin
        if (old_bit) cnt_nxt = cnt_r - 1'b1;
      end
      MODE_FLIP: begin
        cnt_nxt = old_bit ? (cnt_r - 1'b1) : (cnt_r + 1'b1);
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  // candidates: matching bits at or after the start, inside capacity
  always_comb begin
    cand = rd_data_r ^ {WORD_W{~want}};
    if (state_r == S_EXEC) begin
      cand = cand & ({WORD_W{1'b1}} << idx_r[WORD_SH-1:0]);
    end
    if (cur_w_r == LAST_W) begin
      cand = cand & LAST_MASK;
    end
  end

  assign {hit, hit_pos} = first_one(cand);
  assign hit_full       = (32'(cur_w_r) << WORD_SH) | 32'(hit_pos);

  assign wr_en   = (state_r == S_CLEAR) || ((state_r == S_EXEC) && is_modify);
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : cur_w_r;
  assign wr_data = (state_r == S_CLEAR) ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result leaving while the next one is loaded is handled in S_DONE
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == LAST_W) begin
            clr_addr_r <= '0;
            state_r    <= clr_reply_r ? S_DONE : S_IDLE;
          end else begin
            clr_addr_r <= WORD_AW'(clr_addr_r + 1'b1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_r      <= in_ch.mode;
            idx_r       <= in_ch.bit_index;
            cur_w_r     <= in_word32[WORD_AW-1:0];
            res_old_r   <= 1'b0;
            res_found_r <= 1'b0;
            res_fidx_r  <= '0;
            res_oor_r   <= (in_ch.mode <= MODE_NEXT_CLEAR) && in_oor;
            if (in_ch.mode == MODE_CLEAR_ALL) begin
              cnt_r       <= '0;
              clr_reply_r <= 1'b1;
              state_r     <= S_CLEAR;
            end else if (in_ch.mode > MODE_NEXT_CLEAR) begin
              state_r <= S_DONE;
            end else if (in_oor) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC, S_SCAN: begin
          if (state_r == S_EXEC) begin
            res_old_r <= old_bit;
            cnt_r     <= cnt_nxt;
          end
          if (!is_find) begin
            state_r <= S_DONE;
          end else if (hit) begin
            res_found_r <= 1'b1;
            res_fidx_r  <= hit_full[FIDX_W-1:0];
            state_r     <= S_DONE;
          end else if (cur_w_r == LAST_W) begin
            state_r <= S_DONE;
          end else begin
            // next word read is already under way
            cur_w_r <= WORD_AW'(cur_w_r + 1'b1);
            state_r <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_old_r   <= res_old_r;
            out_found_r <= res_found_r;
            out_fidx_r  <= res_fidx_r;
            out_oor_r   <= res_oor_r;
            out_empty_r <= (cnt_r == '0);
            clr_reply_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.old_bit      = out_old_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.found_index  = out_fidx_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_ch.map_empty    = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(BIT_CAPACITY))
    else $error("set-bit count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");

  a_oor_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (!out_old_r && !out_found_r))
    else $error("out-of-range result carries bit data");

  a_fidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_fidx_r == '0))
    else $error("found_index non-zero without a find hit");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !wr_en)
    else $error("memory write during a find scan");

endmodule
